// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/swm2d_pkg.sv
// Package with constants and types for the 2D median filter.
`timescale 1ns / 1ps
package swm2d_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_WINDOW = 7;
  localparam int PIXEL_BITS = 8;
  localparam int LINE_ROWS  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int SIDE_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int WIN_N      = MAX_WINDOW * MAX_WINDOW;
  localparam int CNT_BITS   = $clog2(WIN_N + 1);
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SIDE   = 2'd2
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Tag that travels with each window column through the rank chain.
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } tag_t;
endpackage

// File: hw/rtl/swm2d_stream_if.sv
// Valid/ready stream interfaces for pixels and results.
`timescale 1ns / 1ps
interface swm2d_pixel_if;
  logic   valid;
  logic   ready;
  logic [7:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface swm2d_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] median;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, output median, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input median, input row_end, input frame_end,
                  output ready);
endinterface

// File: hw/rtl/swm2d_rank_cell.sv
// One cell of the rank chain: counts window pixels below and equal to a candidate.
`timescale 1ns / 1ps
module swm2d_rank_cell (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::PIXEL_BITS-1:0] cand,
  input  logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::CNT_BITS-1:0]   lt_in,
  input  logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::CNT_BITS-1:0]   le_in,
  input  logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::PIXEL_BITS-1:0] col,
  input  logic [swm2d_pkg::MAX_WINDOW-1:0]                            col_ok,
  output logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::CNT_BITS-1:0]   lt_out,
  output logic [swm2d_pkg::MAX_WINDOW-1:0][swm2d_pkg::CNT_BITS-1:0]   le_out
);
  import swm2d_pkg::*;
  // Each candidate adds the count of this column's pixels below and equal to it.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        logic [CNT_BITS-1:0] lt, le;
        lt = '0;
        le = '0;
        for (int m = 0; m < MAX_WINDOW; m++) begin
          if (col_ok[m] && col[m] < cand[k]) lt = lt + CNT_BITS'(1);
          if (col_ok[m] && col[m] <= cand[k]) le = le + CNT_BITS'(1);
        end
        lt_out[k] <= lt_in[k] + lt;
        le_out[k] <= le_in[k] + le;
      end
    end
  end
endmodule

// File: hw/rtl/sliding_window_median_2d_top.sv
// Top level of the 2D sliding-window median filter.
`timescale 1ns / 1ps
// The block takes one pixel per clock while the result side is not stalled
// and gives the lower median of every square window that lies wholly
// inside the image, in raster order of the window's top-left corner, with
// row-end and frame-end marks. The throughput is one pixel per cycle when
// not stalled. Each result passes the chain of rank cells that compares
// every candidate pixel of the window against one window column per cell
// and stage. Line buffers are one memory with six pixels per column word,
// read and written once per pixel. Any register write restarts the frame.
// A pipeline stall on the result side freezes the whole pipe, so no results are lost.
module sliding_window_median_2d_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [swm2d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [swm2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  swm2d_pixel_if.sink                           pix,
  swm2d_result_if.source                        res
);
  import swm2d_pkg::*;
  localparam int NW = MAX_WINDOW;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  window_side;

  // Effective clamped settings.
  logic [COL_BITS:0]  w_eff;
  logic [ROW_BITS:0]  h_eff;
  logic [SIDE_BITS-1:0] s_eff;
  always_comb begin
    w_eff = (image_width == '0) ? (COL_BITS+1)'(1) :
            (32'(image_width) > MAX_WIDTH) ? (COL_BITS+1)'(MAX_WIDTH) :
            (COL_BITS+1)'(image_width);
    h_eff = (image_height == '0) ? (ROW_BITS+1)'(1) :
            (32'(image_height) > MAX_HEIGHT) ? (ROW_BITS+1)'(MAX_HEIGHT) :
            (ROW_BITS+1)'(image_height);
    s_eff = (window_side == '0) ? SIDE_BITS'(1) :
            (32'(window_side) > MAX_WINDOW) ? SIDE_BITS'(MAX_WINDOW) :
            SIDE_BITS'(window_side);
  end

  // Pipe advance: stalls only when the output register is full and not taken.
  logic adv;
  logic out_valid;
  assign adv = !out_valid || res.ready;
  assign pix.ready = adv;
  logic take;
  assign take = pix.valid && pix.ready;

  logic [COL_BITS-1:0] column_count;
  logic [ROW_BITS-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      window_side  <= 3'd3;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                            cfg_index == REG_SIDE)) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        REG_SIDE:   window_side  <= cfg_data[2:0];
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (32'(column_count) + 1 >= 32'(w_eff)) begin
        column_count <= '0;
        row_count <= (32'(row_count) + 1 >= 32'(h_eff)) ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Line memory: one word per column, holding the older rows of that column.
  localparam int LW = LINE_ROWS * PIXEL_BITS;
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] line_rd;
  logic [LW-1:0] line_wr;
  logic [LW-1:0] line_fwd;

  // Stage 1: read the column history and register the pixel.
  logic          s1_valid;
  pixel_t        s1_pix;
  logic [COL_BITS-1:0] s1_col;
  logic          s1_emit, s1_re, s1_fe;
  logic          s1_hit;       // same column as the pixel now in stage 1, whose word is being written
  logic [LW-1:0] s1_hitdata;

  logic          emit_now, re_now, fe_now;
  always_comb begin
    emit_now = (32'(row_count) + 1 >= 32'(s_eff)) && (32'(column_count) + 1 >= 32'(s_eff));
    re_now   = (32'(column_count) + 1 == 32'(w_eff));
    fe_now   = re_now && (32'(row_count) + 1 == 32'(h_eff));
  end

  always_ff @(posedge clk) begin
    if (take) line_rd <= line_mem[column_count];
    if (s1_valid && adv) line_mem[s1_col] <= line_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix  <= pix.pixel;
      s1_col  <= column_count;
      s1_emit <= emit_now;
      s1_re   <= re_now;
      s1_fe   <= fe_now;
      // With width one, the column just written is read again at once.
      s1_hit  <= s1_valid && adv && (s1_col == column_count);
      s1_hitdata <= line_wr;
    end
  end

  assign line_fwd = s1_hit ? s1_hitdata : line_rd;
  if (LINE_ROWS > 1) begin : g_shift
    assign line_wr = {line_fwd[LW-PIXEL_BITS-1:0], s1_pix};
  end else begin : g_one
    assign line_wr = s1_pix;
  end

  // Build the new window column: bottom (index side-1) is the pixel,
  // index i holds row history entry (side-2-i). Unused rows are masked.
  logic [NW-1:0][PIXEL_BITS-1:0] new_col;
  logic [NW-1:0]                 row_ok;
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      row_ok[i]  = (i < 32'(s_eff));
      new_col[i] = '0;
      if (i == 32'(s_eff) - 1) new_col[i] = s1_pix;
      else if (i < 32'(s_eff) - 1)
        new_col[i] = line_fwd[(32'(s_eff) - 2 - i) * PIXEL_BITS +: PIXEL_BITS];
    end
  end

  // Window column shift line: stage k holds the column k slots old.
  logic [NW-1:0][NW-1:0][PIXEL_BITS-1:0] win;
  tag_t          w_tag;
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      win[0] <= new_col;
      for (int k = 1; k < NW; k++) win[k] <= win[k-1];
    end
  end
  logic w_valid;
  always_ff @(posedge clk) begin
    if (rst) w_valid <= 1'b0;
    else if (adv) w_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) w_tag <= '{emit: s1_emit && s1_valid, row_end: s1_re, frame_end: s1_fe};
  end

  // Snapshot of the full window: column j (0 = oldest) is win[side-1-j].
  logic [NW-1:0][NW-1:0][PIXEL_BITS-1:0] snap;
  logic [NW-1:0] col_sel;
  always_comb begin
    for (int j = 0; j < NW; j++) begin
      col_sel[j] = (j < 32'(s_eff));
      snap[j] = (j < 32'(s_eff)) ? win[32'(s_eff) - 1 - j] : '0;
    end
  end

  // Rank chain: one cell per window column; candidates and tags ride along.
  logic [NW:0][NW-1:0][NW-1:0][PIXEL_BITS-1:0] ch_win;
  logic [NW:0][NW-1:0][CNT_BITS-1:0] ch_lt [NW];
  logic [NW:0][NW-1:0][CNT_BITS-1:0] ch_le [NW];
  tag_t [NW:0] ch_tag;
  logic [NW:0] ch_v;
  logic [NW:0][NW-1:0] ch_sel;

  always_ff @(posedge clk) begin
    if (rst) ch_v[0] <= 1'b0;
    else if (adv) ch_v[0] <= w_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ch_win[0] <= snap;
      ch_tag[0] <= w_tag;
      ch_sel[0] <= col_sel;
    end
  end

  for (genvar c = 0; c < NW; c++) begin : g_cand
    // The counts start from zero at the head of the chain.
    assign ch_lt[c][0] = '0;
    assign ch_le[c][0] = '0;
    for (genvar k = 0; k < NW; k++) begin : g_cell
      logic [NW-1:0][PIXEL_BITS-1:0] cand;
      logic [NW-1:0]                 ok;
      always_comb begin
        for (int m = 0; m < NW; m++) begin
          cand[m] = ch_win[k][c][m];
          ok[m]   = row_ok[m] && ch_sel[k][k];
        end
      end
      swm2d_rank_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .cand  (cand),
        .lt_in (ch_lt[c][k]),
        .le_in (ch_le[c][k]),
        .col   (ch_win[k][k]),
        .col_ok(ok),
        .lt_out(ch_lt[c][k+1]),
        .le_out(ch_le[c][k+1])
      );
    end
  end
  for (genvar k = 0; k < NW; k++) begin : g_ride
    always_ff @(posedge clk) begin
      if (rst) ch_v[k+1] <= 1'b0;
      else if (adv) ch_v[k+1] <= ch_v[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ch_win[k+1] <= ch_win[k];
        ch_tag[k+1] <= ch_tag[k];
        ch_sel[k+1] <= ch_sel[k];
      end
    end
  end

  // Selection: the median is a candidate with lt < rank <= le.
  logic [CNT_BITS-1:0] rank;
  always_comb rank = CNT_BITS'((32'(s_eff) * 32'(s_eff) + 1) / 2);
  pixel_t med;
  always_comb begin
    med = '0;
    for (int c = 0; c < NW; c++)
      for (int m = 0; m < NW; m++)
        if (c < 32'(s_eff) && m < 32'(s_eff) &&
            ch_lt[c][NW][m] < rank && ch_le[c][NW][m] >= rank)
          med = ch_win[NW][c][m];
  end

  // Output register.
  pixel_t o_med;
  logic   o_re, o_fe;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= ch_v[NW] && ch_tag[NW].emit;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_med <= med;
      o_re  <= ch_tag[NW].row_end;
      o_fe  <= ch_tag[NW].frame_end;
    end
  end
  assign res.valid     = out_valid;
  assign res.median    = o_med;
  assign res.row_end   = o_re;
  assign res.frame_end = o_fe;
endmodule

// File: hw/rtl/swm2d_checker.sv
// Port-level checker for the median filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swm2d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] median,
  input logic       row_end,
  input logic       frame_end
);
  `ASSERT_IMPL(a_fe_re, clk, rst, out_valid && frame_end, row_end, "frame end without row end")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(median), "result dropped")
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready, "input stalled while output empty")
endmodule

bind sliding_window_median_2d_top swm2d_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(pix.valid), .in_ready(pix.ready),
  .out_valid(res.valid), .out_ready(res.ready), .median(res.median),
  .row_end(res.row_end), .frame_end(res.frame_end)
);
